@@ hw/rtl/robl_pkg.sv @@
// Package: item types, stage control type, sRGB linearising table and blend helpers.
package robl_pkg;

   localparam int STAGES = 6;

   localparam logic [24:0] DIV255_MUL = 25'd16843010;

   typedef struct packed {
      logic [7:0] fg_red;
      logic [7:0] fg_green;
      logic [7:0] fg_blue;
      logic [7:0] fg_alpha;
      logic [7:0] ov_red;
      logic [7:0] ov_green;
      logic [7:0] ov_blue;
      logic [7:0] ov_alpha;
      logic       frame_end_in;
   } req_item_type;

   typedef struct packed {
      logic [5:0] out_red;
      logic [5:0] out_green;
      logic [5:0] out_blue;
      logic       frame_end_out;
   } rsp_item_type;

   typedef struct packed {
      logic [STAGES-1:0] adv;
   } stage_ctl_type;

   typedef logic [15:0] lin_tab_type [256];

   // round(65535 * decode(v/255)) on the sRGB transfer curve, built at elaboration
   function automatic lin_tab_type build_lin_tab();
      lin_tab_type tab;
      real         t;
      real         x;
      for (int v = 0; v < 256; v++) begin
         if (v <= 10) begin
            tab[v] = 16'((v * 12850 + 323) / 646);
         end else begin
            t      = (40.0 * v + 561.0) / 10761.0;
            x      = 65535.0 * (t ** 2.4);
            tab[v] = 16'($rtoi(x + 0.5));
         end
      end
      return tab;
   endfunction

   localparam lin_tab_type LIN_TAB = build_lin_tab();

   // floor(x / 255), exact for x < 65536 * 255 (the result is 16 bits wide)
   function automatic logic [15:0] div255(input logic [23:0] x);
      logic [48:0] prod;
      prod = 49'(x) * 49'(DIV255_MUL);
      return prod[47:32];
   endfunction

endpackage

@@ hw/rtl/robl_lane.sv @@
// One colour channel of the blend datapath, six register stages.
module robl_lane
   import robl_pkg::*;
(
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  logic          srgb,
   input  logic [7:0]    fg,
   input  logic [7:0]    fa,
   input  logic [7:0]    ov,
   input  logic [7:0]    oa,
   output logic [5:0]    out
);

   logic [15:0] lin_fg_ff, lin_fg_in;
   logic [15:0] lin_ov_ff, lin_ov_in;
   logic [7:0]  fa1_ff;
   logic [7:0]  oa1_ff;
   logic [23:0] p1_ff, p1_in;
   logic [23:0] ovp2_ff, ovp2_in;
   logic [7:0]  oa2_ff;
   logic [15:0] c1_ff, c1_in;
   logic [23:0] ovp3_ff;
   logic [7:0]  oa3_ff;
   logic [23:0] sum_ff, sum_in;
   logic [15:0] c2_ff, c2_in;
   logic [5:0]  out_ff, out_in;

   logic [23:0] cmul;
   logic [7:0]  inv_oa;
   logic [21:0] y;
   logic [5:0]  q0;
   logic [16:0] rem;

   always_comb begin
      lin_fg_in = srgb ? LIN_TAB[fg] : {fg, fg};
      lin_ov_in = srgb ? LIN_TAB[ov] : {ov, ov};
      p1_in     = 24'(lin_fg_ff) * 24'(fa1_ff);
      ovp2_in   = 24'(lin_ov_ff) * 24'(oa1_ff);
      c1_in     = div255(p1_ff);
      inv_oa    = 8'd255 - oa3_ff;
      cmul      = 24'(c1_ff) * 24'(inv_oa);
      sum_in    = ovp3_ff + cmul;
      c2_in     = div255(sum_ff);
      // floor(c2 * 63 / 65535)
      y         = (22'(c2_ff) << 6) - 22'(c2_ff);
      q0        = y[21:16];
      rem       = 17'(y[15:0]) + 17'(q0);
      out_in    = (rem >= 17'd65535) ? q0 + 6'd1 : q0;
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         lin_fg_ff <= lin_fg_in;
         lin_ov_ff <= lin_ov_in;
         fa1_ff    <= fa;
         oa1_ff    <= oa;
      end
      if (ctl.adv[1]) begin
         p1_ff   <= p1_in;
         ovp2_ff <= ovp2_in;
         oa2_ff  <= oa1_ff;
      end
      if (ctl.adv[2]) begin
         c1_ff   <= c1_in;
         ovp3_ff <= ovp2_ff;
         oa3_ff  <= oa2_ff;
      end
      if (ctl.adv[3]) begin
         sum_ff <= sum_in;
      end
      if (ctl.adv[4]) begin
         c2_ff <= c2_in;
      end
      if (ctl.adv[5]) begin
         out_ff <= out_in;
      end
   end

   assign out = out_ff;

endmodule

@@ hw/rtl/rgba_overlay_blend_to_rgb666_core.sv @@
// Top level: RGBA foreground over black, overlay composite, RGB666 out.
// Six register stages lie between the accepting edge and result valid.
// Throughput: one item per cycle while rsp_ready is high; a full stage holds only while the stage after it holds.
// The stage after each multiply keeps the path to one multiplier.
// Reset (synchronous, high): all stage valid bits clear, srgb_decode returns to 1.
module rgba_overlay_blend_to_rgb666_core
   import robl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic              srgb_ff, srgb_in;
   logic [STAGES-1:0] v_ff, v_in;
   logic [STAGES-1:0] fe_ff, fe_in;
   stage_ctl_type     ctl;
   logic [5:0]        out_r, out_g, out_b;

   always_comb begin
      ctl.adv[STAGES-1] = !v_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         ctl.adv[k] = !v_ff[k] || ctl.adv[k+1];
      end
      v_in  = v_ff;
      fe_in = fe_ff;
      if (ctl.adv[0]) begin
         v_in[0]  = req_valid;
         fe_in[0] = req_item.frame_end_in;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (ctl.adv[k]) begin
            v_in[k]  = v_ff[k-1];
            fe_in[k] = fe_ff[k-1];
         end
      end
      srgb_in = csr_wr_en ? csr_wr_data : srgb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= '0;
         srgb_ff <= 1'b1;
      end else begin
         v_ff    <= v_in;
         srgb_ff <= srgb_in;
      end
      fe_ff <= fe_in;
   end

   robl_lane u_lane_red (
      .clock (clock),
      .ctl   (ctl),
      .srgb  (srgb_ff),
      .fg    (req_item.fg_red),
      .fa    (req_item.fg_alpha),
      .ov    (req_item.ov_red),
      .oa    (req_item.ov_alpha),
      .out   (out_r)
   );

   robl_lane u_lane_green (
      .clock (clock),
      .ctl   (ctl),
      .srgb  (srgb_ff),
      .fg    (req_item.fg_green),
      .fa    (req_item.fg_alpha),
      .ov    (req_item.ov_green),
      .oa    (req_item.ov_alpha),
      .out   (out_g)
   );

   robl_lane u_lane_blue (
      .clock (clock),
      .ctl   (ctl),
      .srgb  (srgb_ff),
      .fg    (req_item.fg_blue),
      .fa    (req_item.fg_alpha),
      .ov    (req_item.ov_blue),
      .oa    (req_item.ov_alpha),
      .out   (out_b)
   );

   assign req_ready              = ctl.adv[0];
   assign rsp_valid              = v_ff[STAGES-1];
   assign rsp_item.out_red       = out_r;
   assign rsp_item.out_green     = out_g;
   assign rsp_item.out_blue      = out_b;
   assign rsp_item.frame_end_out = fe_ff[STAGES-1];

`ifndef SYNTHESIS
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&v_ff))
      else $error("input blocked with a free stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (v_ff == '0))
      else $error("stage valid bits not cleared by reset");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (srgb_ff == $past(csr_wr_data)))
      else $error("srgb_decode write lost");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !ctl.adv[STAGES-1])
      else $error("output stage advanced under stall");
`endif

endmodule

@@ tb/sv/blend_scoreboard_pkg.sv @@
// Scoreboard class: predicts composited RGB666 pixels and checks them in order.
package blend_scoreboard_pkg;
   import robl_pkg::*;

   class blend_scoreboard;
      bit [15:0]    lin_lut [256];
      bit           decode_srgb;
      rsp_item_type expected_px [$];
      int unsigned  mismatches;
      int unsigned  pixels_checked;
      int unsigned  frame_ends;

      function new();
         for (int v = 0; v < 256; v++) lin_lut[v] = srgb_to_lin16(v);
         decode_srgb    = 1'b1;
         mismatches     = 0;
         pixels_checked = 0;
         frame_ends     = 0;
      endfunction

      // exact rounding: smallest r with (2r+1)^5 * 10761^12 > 131070^5 * (40v+561)^12
      function bit [15:0] srgb_to_lin16(int v);
         bit [319:0]  den12;
         bit [319:0]  rhs;
         bit [319:0]  lhs;
         bit [319:0]  step;
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         if (v <= 10) return 16'((v * 12850 + 323) / 646);
         step  = 320'(40 * v + 561);
         den12 = 320'd1;
         repeat (12) den12 = den12 * 320'd10761;
         rhs = 320'd1;
         repeat (5) rhs = rhs * 320'd131070;
         repeat (12) rhs = rhs * step;
         lo = 0;
         hi = 65535;
         while (lo < hi) begin
            mid = (lo + hi) / 2;
            lhs = den12;
            repeat (5) lhs = lhs * 320'(2 * mid + 1);
            if (lhs > rhs) hi = mid;
            else lo = mid + 1;
         end
         return 16'(lo);
      endfunction

      function int unsigned to_linear(bit [7:0] v);
         if (decode_srgb) return int'(lin_lut[v]);
         return int'(v) * 257;
      endfunction

      function bit [5:0] blend_channel(bit [7:0] fg, bit [7:0] fa, bit [7:0] ov, bit [7:0] oa);
         int unsigned c1;
         int unsigned c2;
         c1 = to_linear(fg) * fa / 255;
         c2 = (to_linear(ov) * oa + c1 * (255 - oa)) / 255;
         return 6'(c2 * 63 / 65535);
      endfunction

      function void note_pixel(req_item_type px);
         rsp_item_type exp_px;
         exp_px.out_red       = blend_channel(px.fg_red, px.fg_alpha, px.ov_red, px.ov_alpha);
         exp_px.out_green     = blend_channel(px.fg_green, px.fg_alpha, px.ov_green, px.ov_alpha);
         exp_px.out_blue      = blend_channel(px.fg_blue, px.fg_alpha, px.ov_blue, px.ov_alpha);
         exp_px.frame_end_out = px.frame_end_in;
         expected_px.push_back(exp_px);
      endfunction

      function void check_pixel(rsp_item_type got);
         rsp_item_type exp_px;
         if (expected_px.size() == 0) begin
            $display("%0t: unexpected item, expected none got %p", $time, got);
            mismatches++;
            return;
         end
         exp_px = expected_px.pop_front();
         pixels_checked++;
         if (got.frame_end_out === 1'b1) frame_ends++;
         if (got.out_red !== exp_px.out_red) begin
            $display("%0t: out_red expected %0d got %0d", $time, exp_px.out_red, got.out_red);
            mismatches++;
         end
         if (got.out_green !== exp_px.out_green) begin
            $display("%0t: out_green expected %0d got %0d", $time, exp_px.out_green,
                     got.out_green);
            mismatches++;
         end
         if (got.out_blue !== exp_px.out_blue) begin
            $display("%0t: out_blue expected %0d got %0d", $time, exp_px.out_blue, got.out_blue);
            mismatches++;
         end
         if (got.frame_end_out !== exp_px.frame_end_out) begin
            $display("%0t: frame_end_out expected %0b got %0b", $time, exp_px.frame_end_out,
                     got.frame_end_out);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_px.size();
      endfunction
   endclass

endpackage

@@ tb/sv/tb_rgba_overlay_blend_to_rgb666_core.sv @@
// Testbench: directed and random pixels through the overlay blend core, checked in order.
module tb_rgba_overlay_blend_to_rgb666_core;
   import robl_pkg::*;
   import blend_scoreboard_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1000000;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_item_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en   = 1'b0;
   logic         csr_wr_data = 1'b0;

   blend_scoreboard sb;
   bit              calm;
   bit              hold_output;
   int unsigned     cycle_count = 0;
   int unsigned     pixels_sent = 0;
   int unsigned     long_stalls = 0;

   rgba_overlay_blend_to_rgb666_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic bit [7:0] knee_value();
      if ($urandom_range(0, 1)) return 8'($urandom_range(0, 16));
      return 8'($urandom_range(240, 255));
   endfunction

   function automatic bit [7:0] alpha_value();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_item_type rand_pixel();
      req_item_type px;
      bit [7:0]     v;
      px = req_item_type'(65'({$urandom, $urandom, $urandom}));
      case ($urandom_range(0, 9))
         6: begin
            px.fg_alpha = alpha_value();
            px.ov_alpha = alpha_value();
         end
         7: begin
            px.fg_red   = knee_value();
            px.fg_green = knee_value();
            px.fg_blue  = knee_value();
            px.ov_red   = knee_value();
            px.ov_green = knee_value();
            px.ov_blue  = knee_value();
         end
         8: begin
            px.fg_alpha = 8'd255;
            px.ov_alpha = 8'd0;
         end
         9: begin
            v = 8'($urandom);
            px.fg_red   = v;
            px.fg_green = v;
            px.fg_blue  = v;
            px.ov_red   = ~v;
            px.ov_green = ~v;
            px.ov_blue  = ~v;
         end
         default: ;
      endcase
      px.frame_end_in = ($urandom_range(0, 15) == 0);
      return px;
   endfunction

   // fg r,g,b,a then ov r,g,b,a then frame end
   function automatic req_item_type directed_pixel(int k);
      case (k)
         0:  return {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
         1:  return {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
         2:  return {8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
         3:  return {8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0};
         4:  return {8'd10, 8'd11, 8'd12, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
         5:  return {8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd1, 8'd255, 1'b0};
         6:  return {8'd200, 8'd100, 8'd50, 8'd128, 8'd10, 8'd11, 8'd255, 8'd128, 1'b1};
         7:  return {8'd1, 8'd2, 8'd3, 8'd1, 8'd254, 8'd253, 8'd252, 8'd254, 1'b0};
         8:  return {8'd128, 8'd128, 8'd128, 8'd255, 8'd64, 8'd64, 8'd64, 8'd127, 1'b0};
         9:  return {8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0};
         10: return {8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 1'b1};
         default: return {8'd11, 8'd10, 8'd9, 8'd255, 8'd12, 8'd13, 8'd14, 8'd255, 1'b0};
      endcase
   endfunction

   task automatic offer_pixel(input req_item_type px);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= px;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(px);
      pixels_sent++;
   endtask

   task automatic offer_directed();
      for (int k = 0; k < 12; k++) offer_pixel(directed_pixel(k));
   endtask

   task automatic offer_random(input int unsigned count, input int unsigned squeeze_at);
      for (int unsigned i = 0; i < count; i++) begin
         if (i == squeeze_at) hold_output = 1'b1;
         offer_pixel(rand_pixel());
      end
   endtask

   // drain the pipeline, then change the decode mode
   task automatic drain_and_set_decode(input bit decode);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= decode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.decode_srgb = decode;
   endtask

   // output side: random back-pressure plus one long hold on request
   initial begin : output_drain
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_pixel(rsp_item);
         if (hold_output) begin
            hold_output = 1'b0;
            hold = 80;
            long_stalls++;
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20) hold = pick_gap();
         end
      end
   end

   initial begin : stimulus
      sb = new();
      calm = 1'b0;
      hold_output = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      offer_directed();
      drain_and_set_decode(1'b0);
      offer_directed();
      offer_random(500, 500);

      drain_and_set_decode(1'b1);
      offer_random(500, 100);

      drain_and_set_decode(1'b0);
      calm = 1'b1;
      offer_random(300, 300);

      drain_and_set_decode(1'b1);
      calm = 1'b0;
      offer_random(500, 500);

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d pixels sent, %0d checked, %0d frame ends, sRGB decode on and off",
               pixels_sent, sb.pixels_checked, sb.frame_ends);
      $display("%0d long output stalls, %0d mismatches", long_stalls, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
